@@ sv/bmad_pkg.sv @@
// ============================================================================
// bmad_pkg
// Shared types, constants and decode functions for the banked memory access
// decoder: access and result item layouts, address map limits, card masks.
// ============================================================================
package bmad_pkg;

    localparam int AddrWidth  = 16;
    localparam int PhysWidth  = 18;
    localparam int ByteWidth  = 8;
    localparam int OffWidth   = 10;
    localparam int BankWidth  = 3;
    localparam int CardWidth  = 6;
    localparam int CfgIdxWidth  = 1;
    localparam int CfgDataWidth = 6;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] REG_RAM_BANK        = 1'd0;
    localparam logic [CfgIdxWidth-1:0] REG_CARDS_INSTALLED = 1'd1;

    localparam logic                 RAM_BANK_RESET = 1'b0;
    localparam logic [CardWidth-1:0] CARDS_RESET    = 6'd4;

    // card mask bits
    localparam logic [CardWidth-1:0] CARD_210M  = 6'h01;
    localparam logic [CardWidth-1:0] CARD_211M  = 6'h02;
    localparam logic [CardWidth-1:0] CARD_212M  = 6'h04;
    localparam logic [CardWidth-1:0] CARD_2H16M = 6'h08;
    localparam logic [CardWidth-1:0] CARD_2H32M = 6'h10;
    localparam logic [CardWidth-1:0] CARD_2H64M = 6'h20;

    // logical address map
    localparam logic [AddrWidth-1:0] LCD_BASE     = 16'h2800;
    localparam logic [AddrWidth-1:0] LCD_LAST     = 16'h2B7B;
    localparam logic [AddrWidth-1:0] BANK_BASE    = 16'h3400;
    localparam logic [AddrWidth-1:0] BANK_LAST    = 16'h35FF;
    localparam logic [AddrWidth-1:0] KEY_BASE     = 16'h3E00;
    localparam logic [AddrWidth-1:0] IO_LAST      = 16'h3FFF;
    localparam logic [AddrWidth-1:0] ROM_BASE     = 16'h4000;
    localparam logic [AddrWidth-1:0] ROM_LAST     = 16'h7FFF;
    localparam logic [AddrWidth-1:0] RAM_BASE     = 16'h8000;

    // translation offsets
    localparam logic [PhysWidth-1:0] ROM_OFFSET    = 18'h0C000;
    localparam logic [PhysWidth-1:0] RAM_OFFSET    = 18'h28000;

    localparam logic [BankWidth-1:0] BANK_MASK     = 3'h7;
    localparam logic [ByteWidth-1:0] KEY_ALL       = 8'h7F;

    typedef struct packed {
        logic                 operation;
        logic [AddrWidth-1:0] cpu_address;
        logic [ByteWidth-1:0] write_byte;
    } access_t;

    typedef struct packed {
        logic [PhysWidth-1:0] physical_address;
        logic                 permitted;
        logic                 lcd_dirty;
        logic [OffWidth-1:0]  lcd_offset;
        logic                 key_strobe_valid;
        logic [ByteWidth-1:0] key_strobe;
    } result_t;

    function automatic logic [CardWidth-1:0] card_need(input logic [PhysWidth-1:0] phys);
        logic [CardWidth-1:0] m;
        m = '0;
        if (phys >= 18'h30000 && phys <= 18'h33FFF)
            m = CARD_2H64M | CARD_2H32M;
        else if (phys >= 18'h34000 && phys <= 18'h35FFF)
            m = CARD_2H64M | CARD_2H32M | CARD_2H16M;
        else if (phys >= 18'h36000 && phys <= 18'h36FFF)
            m = CARD_2H64M | CARD_2H32M | CARD_2H16M | CARD_212M;
        else if (phys >= 18'h37000 && phys <= 18'h377FF)
            m = CARD_2H64M | CARD_2H32M | CARD_2H16M | CARD_212M | CARD_211M;
        else if (phys >= 18'h37800 && phys <= 18'h37FFF)
            m = CARD_2H64M | CARD_2H32M | CARD_2H16M | CARD_212M | CARD_211M | CARD_210M;
        else if (phys >= 18'h38000)
            m = CARD_2H64M;
        return m;
    endfunction

    function automatic logic [ByteWidth-1:0] key_decode(input logic [ByteWidth-1:0] b);
        logic [ByteWidth-1:0] s;
        s = '0;
        unique case (b[3:0])
            4'd1:    s = 8'h01;
            4'd2:    s = 8'h02;
            4'd3:    s = 8'h04;
            4'd4:    s = 8'h08;
            4'd5:    s = 8'h10;
            4'd6:    s = 8'h20;
            4'd7:    s = 8'h40;
            4'd8:    s = 8'h80;
            4'd15:   s = KEY_ALL;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

@@ sv/banked_memory_access_decoder.sv @@
// ============================================================================
// banked_memory_access_decoder
// Decodes one CPU bus access per cycle while not stalled: bank translation,
// write permission, LCD dirty offset and keyboard strobe; holds the ROM bank, RAM bank and cards_installed registers.
// ============================================================================
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall   | in_item  (access_t)
//  out     | output    | out_valid / out_stall | out_item (result_t)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
//  One item per cycle while in_stall is low; a taken item is held in the
//  input register s1_reg, then its decoded result in the result register
//  out_reg, which drives out_item.
//  Reset clears the pipeline valid bits, rom_bank to 0, ram_bank to 0,
//  cards_installed to 4. A stalled result holds; in_stall rises only when
//  both registers are full and out_stall is high.
// ============================================================================
module banked_memory_access_decoder (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  bmad_pkg::access_t                      in_item,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output bmad_pkg::result_t                      out_item,
    input  logic                                   cfg_we,
    input  logic [bmad_pkg::CfgIdxWidth-1:0]       cfg_index,
    input  logic [bmad_pkg::CfgDataWidth-1:0]      cfg_data
);
    import bmad_pkg::*;

    logic                 s1_valid_reg;
    access_t              s1_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    logic [BankWidth-1:0] rom_bank_reg;
    logic [BankWidth-1:0] rom_bank_next;
    logic                 ram_bank_reg;
    logic [CardWidth-1:0] cards_reg;

    logic                 out_free;
    logic                 s1_move;
    logic                 in_take;
    logic                 bank_load;
    result_t              res_next;
    logic [AddrWidth-1:0] a;
    logic [PhysWidth-1:0] phys;
    logic [PhysWidth-1:0] addr_ext;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign a        = s1_reg.cpu_address;
    assign addr_ext = {{(PhysWidth-AddrWidth){1'b0}}, a};

    always_comb
    begin
        if (a >= ROM_BASE && a <= ROM_LAST)
            phys = addr_ext + ROM_OFFSET + {1'b0, rom_bank_reg, 14'b0};
        else if (a >= RAM_BASE)
            phys = addr_ext + RAM_OFFSET + {2'b0, ram_bank_reg, 15'b0};
        else
            phys = addr_ext;
    end

    always_comb
    begin
        res_next                  = '0;
        res_next.physical_address = phys;
        bank_load                 = 1'b0;
        priority if (s1_reg.operation == OP_READ)
            res_next.permitted = 1'b1;
        else if (a < LCD_BASE)
            res_next.permitted = 1'b0;
        else if (a <= LCD_LAST)
        begin
            res_next.permitted  = 1'b1;
            res_next.lcd_dirty  = 1'b1;
            res_next.lcd_offset = OffWidth'(a - LCD_BASE);
        end
        else if (a >= BANK_BASE && a <= BANK_LAST)
        begin
            res_next.permitted = 1'b1;
            bank_load          = 1'b1;
        end
        else if (a >= KEY_BASE && a <= IO_LAST)
        begin
            res_next.permitted        = 1'b1;
            res_next.key_strobe_valid = 1'b1;
            res_next.key_strobe       = key_decode(s1_reg.write_byte);
        end
        else if (a <= IO_LAST)
            res_next.permitted = 1'b1;
        else if (a <= ROM_LAST)
            res_next.permitted = 1'b0;
        else
            res_next.permitted = (card_need(phys) & cards_reg) != '0;
    end

    assign rom_bank_next = (s1_move && bank_load)
                         ? (s1_reg.write_byte[BankWidth-1:0] & BANK_MASK)
                         : rom_bank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rom_bank_reg  <= '0;
            ram_bank_reg  <= RAM_BANK_RESET;
            cards_reg     <= CARDS_RESET;
        end
        else
        begin
            if (!s1_valid_reg || s1_move)
                s1_valid_reg <= in_take;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            rom_bank_reg <= rom_bank_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RAM_BANK:        ram_bank_reg <= cfg_data[0];
                    REG_CARDS_INSTALLED: cards_reg    <= cfg_data[CardWidth-1:0];
                    default:             ;
                endcase
            end
        end
    end

    // payload: load on take, hold on stall
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_reg <= in_item;
        if (s1_move)
            out_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_bank_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_move && bank_load) |=> $stable(rom_bank_reg))
        else $error("rom bank changed without a bank load");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.lcd_dirty && out_reg.key_strobe_valid))
        else $error("lcd and key flags both set");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule
